// File: src/swec_pkg.sv
// ----------------------------------------------------------------------------
// swec_pkg - shared types and constants for the sliding window event counter
// Request structs, cell control struct, item kinds and saturating arithmetic.
// ----------------------------------------------------------------------------
package swec_pkg;

  localparam int KIND_W  = 2;
  localparam int COUNT_W = 32;
  localparam int TS_W    = 48;
  localparam int TOTAL_W = 38;
  localparam int USED_W  = 7;
  localparam int IVAL_W  = 48;

  localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REFRESH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [USED_W-1:0]  USED_MAX     = {USED_W{1'b1}};
  localparam logic [IVAL_W-1:0]  IVAL_RST     = 48'd10000000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] event_count;
    logic [TS_W-1:0]    time_stamp;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] window_total;
    logic [USED_W-1:0]  buckets_used;
    logic               overflowed;
  } out_item_t;

  // per-cell control: shift takes the upper neighbor, load overrides it
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {{(TOTAL_W+1-COUNT_W){1'b0}}, b};
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [TOTAL_W-1:0] bx;
    bx = {{(TOTAL_W-COUNT_W){1'b0}}, b};
    return (bx > a) ? '0 : a - bx;
  endfunction

endpackage

// File: src/swec_cell.sv
// ----------------------------------------------------------------------------
// swec_cell - one bucket slot of the bucket chain
// Holds a count and a timestamp; shifts from its upper neighbor or loads new.
// ----------------------------------------------------------------------------
module swec_cell #(
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  swec_pkg::cell_ctl_t           ctl,
  input  logic [swec_pkg::COUNT_W-1:0]  load_count,
  input  logic [TIME_BITS-1:0]          load_tstamp,
  input  logic [swec_pkg::COUNT_W-1:0]  nbr_count,
  input  logic [TIME_BITS-1:0]          nbr_tstamp,
  output logic [swec_pkg::COUNT_W-1:0]  bkt_count,
  output logic [TIME_BITS-1:0]          bkt_tstamp
);

  logic [swec_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [TIME_BITS-1:0]         tstamp_r, tstamp_nxt;

  always_comb begin
    count_nxt  = count_r;
    tstamp_nxt = tstamp_r;
    if (ctl.load) begin
      count_nxt  = load_count;
      tstamp_nxt = load_tstamp;
    end else if (ctl.shift) begin
      count_nxt  = nbr_count;
      tstamp_nxt = nbr_tstamp;
    end
  end

  always_ff @(posedge clk) begin
    count_r  <= count_nxt;
    tstamp_r <= tstamp_nxt;
  end

  assign bkt_count  = count_r;
  assign bkt_tstamp = tstamp_r;

endmodule

// File: src/sliding_window_event_counter.sv
// ----------------------------------------------------------------------------
// sliding_window_event_counter - bucketed event count over a sliding window
// Buckets live in a chain of cells, oldest in cell 0; expiry shifts the chain.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | swec_pkg::in_item_t
//   out_    | output    | out_valid/out_stall| swec_pkg::out_item_t
//   cfg_    | input     | cfg_we             | interval_ticks (48 bits)
//
// An item is accepted in S_IDLE and recorded or cleared in S_STEP; S_EXP then
// pops one bucket per cycle from cell 0 of the chain for each bucket the item
// expires and then loads the output register. Reset (rst_n low, synchronous)
// empties the store and sets the interval to 10000000. A stalled result holds
// in the output register; the next request is still accepted and waits for the
// register only at its last cycle.
module sliding_window_event_counter #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  swec_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swec_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [swec_pkg::IVAL_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (TIME_BITS > swec_pkg::IVAL_W) ? TIME_BITS : swec_pkg::IVAL_W;
  localparam int OW = (CW > swec_pkg::USED_W) ? CW : swec_pkg::USED_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_EXP  = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  swec_pkg::in_item_t              item_r;
  logic [swec_pkg::IVAL_W-1:0]     interval_r;
  logic [CW-1:0]                   occ_r, occ_nxt;
  logic [swec_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic [TIME_BITS-1:0]            newest_t_r, newest_t_nxt;
  logic [swec_pkg::COUNT_W-1:0]    newest_c_r, newest_c_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            exp_en_r, exp_en_nxt;
  logic                            out_valid_r, out_valid_nxt;
  swec_pkg::out_item_t             out_item_r, out_item_nxt;

  logic [TIME_BITS-1:0]            now;
  logic                            shift_en, load_en;
  logic [CW-1:0]                   load_idx;
  logic [swec_pkg::COUNT_W-1:0]    load_count;

  logic [swec_pkg::COUNT_W-1:0]    c_q [DEPTH];
  logic [TIME_BITS-1:0]            t_q [DEPTH];
  swec_pkg::cell_ctl_t             ctl [DEPTH];

  // record step
  logic                            backw, merge, full;
  logic [CW-1:0]                   occ_e;
  logic [swec_pkg::TOTAL_W-1:0]    tot_e, tot_pop;
  logic [swec_pkg::COUNT_W:0]      msum;
  logic [swec_pkg::COUNT_W-1:0]    merged;

  // expire step
  logic [TIME_BITS-1:0]            age;
  logic                            stop, out_free;
  logic [OW-1:0]                   occ_ext;

  assign now = TIME_BITS'(item_r.time_stamp);

  // ---------------- cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [swec_pkg::COUNT_W-1:0] nc;
    logic [TIME_BITS-1:0]         nt;
    if (i == DEPTH - 1) begin : g_last
      assign nc = '0;
      assign nt = '0;
    end else begin : g_mid
      assign nc = c_q[i+1];
      assign nt = t_q[i+1];
    end
    assign ctl[i].shift = shift_en;
    assign ctl[i].load  = load_en && (load_idx == CW'(i));
    swec_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .load_count (load_count),
      .load_tstamp(now),
      .nbr_count  (nc),
      .nbr_tstamp (nt),
      .bkt_count  (c_q[i]),
      .bkt_tstamp (t_q[i])
    );
  end

  // ---------------- record datapath
  always_comb begin
    backw   = (occ_r != '0) && (newest_t_r > now);
    occ_e   = backw ? '0 : occ_r;
    tot_e   = backw ? '0 : total_r;
    merge   = (occ_e != '0) && (newest_t_r == now);
    msum    = {1'b0, newest_c_r} + {1'b0, item_r.event_count};
    merged  = msum[swec_pkg::COUNT_W] ? swec_pkg::COUNT_MAX : msum[swec_pkg::COUNT_W-1:0];
    full    = (occ_e == CW'(DEPTH));
    tot_pop = swec_pkg::sat_sub(tot_e, full ? c_q[0] : '0);
  end

  // ---------------- expiry test on the oldest bucket
  always_comb begin
    age     = now - t_q[0];
    stop    = !exp_en_r || (occ_r == '0) || (now < t_q[0]) ||
              (MW'(age) < MW'(interval_r));
    out_free = !out_valid_r || !out_stall;
    occ_ext = OW'(occ_r);
  end

  // ---------------- control
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    total_nxt     = total_r;
    newest_t_nxt  = newest_t_r;
    newest_c_nxt  = newest_c_r;
    ovf_nxt       = ovf_r;
    exp_en_nxt    = exp_en_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    shift_en      = 1'b0;
    load_en       = 1'b0;
    load_idx      = '0;
    load_count    = item_r.event_count;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        ovf_nxt    = 1'b0;
        exp_en_nxt = 1'b0;
        state_nxt  = S_EXP;
        case (item_r.kind)
          swec_pkg::KIND_RECORD: begin
            exp_en_nxt = 1'b1;
            load_en    = 1'b1;
            if (merge) begin
              load_idx     = occ_e - CW'(1);
              load_count   = merged;
              newest_c_nxt = merged;
              occ_nxt      = occ_e;
              total_nxt    = swec_pkg::sat_add(tot_e, merged - newest_c_r);
            end else begin
              // full store: oldest bucket leaves while the new one goes in
              shift_en     = full;
              ovf_nxt      = full;
              load_idx     = full ? occ_e - CW'(1) : occ_e;
              occ_nxt      = full ? occ_e : occ_e + CW'(1);
              total_nxt    = swec_pkg::sat_add(tot_pop, item_r.event_count);
              newest_t_nxt = now;
              newest_c_nxt = item_r.event_count;
            end
          end
          swec_pkg::KIND_REFRESH: begin
            exp_en_nxt = 1'b1;
          end
          swec_pkg::KIND_CLEAR: begin
            occ_nxt   = '0;
            total_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_EXP: begin
        if (!stop) begin
          shift_en  = 1'b1;
          occ_nxt   = occ_r - CW'(1);
          total_nxt = swec_pkg::sat_sub(total_r, c_q[0]);
        end else if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.window_total = total_r;
          out_item_nxt.buckets_used = (occ_ext > OW'(swec_pkg::USED_MAX)) ?
                                      swec_pkg::USED_MAX : occ_ext[swec_pkg::USED_W-1:0];
          out_item_nxt.overflowed   = ovf_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      exp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      interval_r  <= swec_pkg::IVAL_RST;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      exp_en_r    <= exp_en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      item_r <= in_item;
    end
    newest_t_r <= newest_t_nxt;
    newest_c_r <= newest_c_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: src/swec_checker.sv
// ----------------------------------------------------------------------------
// swec_checker - port-level checks for the sliding window event counter
// Watches the request channels and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module swec_checker #(
  parameter int DEPTH = 64
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input swec_pkg::out_item_t         out_item
);

  localparam int DW = $clog2(DEPTH + 1) + 1;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // one request at a time: busy right after an accepted request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DW'(out_item.buckets_used) <= DW'(DEPTH)))
    else $error("bucket count above store depth");

  // an empty window carries no events
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.buckets_used == '0) |-> (out_item.window_total == '0))
    else $error("nonzero total with no buckets");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sliding_window_event_counter swec_checker #(.DEPTH(DEPTH)) u_swec_checker (.*);

// File: sim/sliding_window_event_counter_test.sv
// ----------------------------------------------------------------------------
// sliding_window_event_counter_test - self-checking bench for the window counter
// Walks a short table of directed requests, then random phases at several
// window lengths. A behavioral copy of the bucket store predicts every result;
// the sender runs in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module sliding_window_event_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = 64;
  localparam int PHASE_ITEMS = 76;
  localparam int ROW_SLOTS = 24;
  localparam int TALLY_SLOTS = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [swec_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [swec_pkg::IVAL_W-1:0] IVAL_MAX = {swec_pkg::IVAL_W{1'b1}};
  localparam logic [swec_pkg::TS_W-1:0] TS_MAX = {swec_pkg::TS_W{1'b1}};

  typedef struct {
    bit                          set_interval;
    logic [swec_pkg::IVAL_W-1:0] interval;
    swec_pkg::in_item_t          req;
    bit                          typed;
    swec_pkg::out_item_t         want;
  } step_row_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  swec_pkg::in_item_t          in_item = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  swec_pkg::out_item_t         out_item;
  logic                        cfg_we = 1'b0;
  logic [swec_pkg::IVAL_W-1:0] cfg_wdata = '0;

  // behavioral copy of the bucket store
  logic [swec_pkg::COUNT_W-1:0] win_counts [WIN_DEPTH];
  logic [swec_pkg::TS_W-1:0]    win_times [WIN_DEPTH];
  int                           win_head = 0;
  int                           win_tail = 0;
  int                           win_used = 0;
  logic [swec_pkg::TOTAL_W-1:0] win_total = '0;
  logic [swec_pkg::IVAL_W-1:0]  win_interval = swec_pkg::IVAL_RST;

  // expected results in flight; each counter has a single writer
  swec_pkg::out_item_t tally_fifo [TALLY_SLOTS];
  int unsigned         tally_wr_cnt = 0;
  int unsigned         tally_rd_cnt = 0;

  step_row_t   dir_rows [ROW_SLOTS];
  int          dir_count = 0;

  int          fail_count = 0;
  int unsigned burst_left = 0;

  sliding_window_event_counter #(
    .DEPTH(WIN_DEPTH),
    .TIME_BITS(swec_pkg::TS_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_window();
    win_head = 0;
    win_tail = 0;
    win_used = 0;
    win_total = '0;
  endfunction

  function automatic void drop_oldest();
    win_total = win_total - win_counts[win_head];
    win_head = (win_head + 1) % WIN_DEPTH;
    win_used--;
  endfunction

  function automatic void expire_window(logic [swec_pkg::TS_W-1:0] now);
    while (win_used > 0 && now >= win_times[win_head] &&
           now - win_times[win_head] >= win_interval)
      drop_oldest();
  endfunction

  function automatic swec_pkg::out_item_t tally_step(swec_pkg::in_item_t req);
    swec_pkg::out_item_t            res;
    int                             newest;
    logic [swec_pkg::COUNT_W:0]     merged;
    res = '0;
    case (req.kind)
      swec_pkg::KIND_RECORD: begin
        newest = (win_tail + WIN_DEPTH - 1) % WIN_DEPTH;
        // time went backwards: start over
        if (win_used > 0 && win_times[newest] > req.time_stamp)
          clear_window();
        if (win_used > 0 && win_times[newest] == req.time_stamp) begin
          merged = {1'b0, win_counts[newest]} + {1'b0, req.event_count};
          if (merged[swec_pkg::COUNT_W])
            merged = {1'b0, swec_pkg::COUNT_MAX};
          win_total = win_total +
                      (merged[swec_pkg::COUNT_W-1:0] - win_counts[newest]);
          win_counts[newest] = merged[swec_pkg::COUNT_W-1:0];
        end else begin
          if (win_used >= WIN_DEPTH) begin
            drop_oldest();
            res.overflowed = 1'b1;
          end
          win_counts[win_tail] = req.event_count;
          win_times[win_tail] = req.time_stamp;
          win_tail = (win_tail + 1) % WIN_DEPTH;
          win_used++;
          win_total = win_total + req.event_count;
        end
        expire_window(req.time_stamp);
      end
      swec_pkg::KIND_REFRESH: expire_window(req.time_stamp);
      swec_pkg::KIND_CLEAR: clear_window();
      default: ;
    endcase
    res.window_total = win_total;
    res.buckets_used = (win_used > 127) ? swec_pkg::USED_MAX :
                       swec_pkg::USED_W'(win_used);
    return res;
  endfunction

  function automatic step_row_t req_row(logic [swec_pkg::KIND_W-1:0] kind,
                                        logic [swec_pkg::COUNT_W-1:0] cnt,
                                        logic [swec_pkg::TS_W-1:0] ts, bit typed = 1'b0,
                                        logic [swec_pkg::TOTAL_W-1:0] total = '0,
                                        logic [swec_pkg::USED_W-1:0] used = '0);
    step_row_t row;
    row = '{set_interval: 1'b0, interval: '0, req: '0, typed: typed, want: '0};
    row.req.kind = kind;
    row.req.event_count = cnt;
    row.req.time_stamp = ts;
    row.want.window_total = total;
    row.want.buckets_used = used;
    return row;
  endfunction

  function automatic step_row_t interval_row(logic [swec_pkg::IVAL_W-1:0] v);
    step_row_t row;
    row = '{set_interval: 1'b1, interval: v, req: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic void add_row(input step_row_t row);
    dir_rows[dir_count] = row;
    dir_count++;
  endfunction

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // valid stays high on return; a gap before the next request or an idle lowers it
  task automatic send_request(input swec_pkg::in_item_t req, input bit typed,
                              input swec_pkg::out_item_t want);
    swec_pkg::out_item_t predicted;
    in_item <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = tally_step(req);
    tally_fifo[tally_wr_cnt % TALLY_SLOTS] = typed ? want : predicted;
    tally_wr_cnt++;
  endtask

  task automatic set_window_length(input logic [swec_pkg::IVAL_W-1:0] v);
    in_valid <= 1'b0;
    while (tally_wr_cnt != tally_rd_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_interval = v;
  endtask

  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 120);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 5) != 0);
    endcase
  end

  always @(posedge clk) begin
    swec_pkg::out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (tally_wr_cnt == tally_rd_cnt) begin
        $error("unexpected result: window_total %0d buckets_used %0d overflowed %0d",
               out_item.window_total, out_item.buckets_used, out_item.overflowed);
        fail_count++;
      end else begin
        exp_res = tally_fifo[tally_rd_cnt % TALLY_SLOTS];
        tally_rd_cnt++;
        if (out_item.window_total !== exp_res.window_total) begin
          $error("window_total: expected %0d, got %0d",
                 exp_res.window_total, out_item.window_total);
          fail_count++;
        end
        if (out_item.buckets_used !== exp_res.buckets_used) begin
          $error("buckets_used: expected %0d, got %0d",
                 exp_res.buckets_used, out_item.buckets_used);
          fail_count++;
        end
        if (out_item.overflowed !== exp_res.overflowed) begin
          $error("overflowed: expected %0d, got %0d",
                 exp_res.overflowed, out_item.overflowed);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [swec_pkg::IVAL_W-1:0] phase_iv[7];
    logic [swec_pkg::IVAL_W-1:0] iv;
    logic [swec_pkg::TS_W-1:0]   cur_time;
    logic [63:0]                 wide;
    longint unsigned             span;
    int unsigned                 step_max;
    swec_pkg::in_item_t          req;
    int                          pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, zero counts, merge saturation, exact-age expiry
    add_row(req_row(swec_pkg::KIND_REFRESH, 32'd0, 48'd0, 1'b1, 38'd0, 7'd0));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd0, 48'd100, 1'b1, 38'd0, 7'd1));
    add_row(req_row(swec_pkg::KIND_RECORD, swec_pkg::COUNT_MAX, 48'd100, 1'b1,
                    38'hFFFF_FFFF, 7'd1));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd5, 48'd100, 1'b1, 38'hFFFF_FFFF, 7'd1));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd7, 48'd200));
    add_row(req_row(swec_pkg::KIND_REFRESH, 32'd0, 48'd10000100, 1'b1, 38'd7, 7'd1));
    // time going backwards: refresh keeps, record clears
    add_row(req_row(swec_pkg::KIND_REFRESH, 32'd99, 48'd50));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd3, 48'd150));
    add_row(req_row(KIND_UNUSED, swec_pkg::COUNT_MAX, TS_MAX));
    add_row(req_row(swec_pkg::KIND_CLEAR, swec_pkg::COUNT_MAX, TS_MAX, 1'b1, 38'd0, 7'd0));
    add_row(req_row(swec_pkg::KIND_RECORD, swec_pkg::COUNT_MAX, TS_MAX, 1'b1,
                    38'hFFFF_FFFF, 7'd1));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd1, 48'd0, 1'b1, 38'd1, 7'd1));
    add_row(req_row(swec_pkg::KIND_REFRESH, 32'd12345, 48'd9999999));
    // zero window: even the fresh bucket expires
    add_row(interval_row('0));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd9, 48'd5, 1'b1, 38'd0, 7'd0));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd4, 48'd5));
    add_row(interval_row(IVAL_MAX));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd1, 48'd0, 1'b1, 38'd1, 7'd1));
    add_row(req_row(swec_pkg::KIND_RECORD, 32'd2, TS_MAX, 1'b1, 38'd2, 7'd1));
    add_row(req_row(swec_pkg::KIND_REFRESH, 32'd0, 48'd0, 1'b1, 38'd2, 7'd1));

    for (int i = 0; i < dir_count; i++) begin
      if (dir_rows[i].set_interval) begin
        set_window_length(dir_rows[i].interval);
      end else begin
        pace_sender();
        send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    wide = {$urandom, $urandom};
    phase_iv = '{swec_pkg::IVAL_RST, 48'd0, 48'd1, 48'd100, 48'd5000, IVAL_MAX,
                 wide[swec_pkg::IVAL_W-1:0]};

    foreach (phase_iv[p]) begin
      iv = phase_iv[p];
      set_window_length(iv);
      // steps small enough that a few dozen buckets stay live
      span = iv / 16;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      if (span < 3) span = 3;
      step_max = 32'(span);
      wide = {$urandom, $urandom};
      cur_time = wide[swec_pkg::TS_W-1:0];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        req.event_count = $urandom;
        req.time_stamp = wide[swec_pkg::TS_W-1:0];
        if (pick < 70) begin
          req.kind = swec_pkg::KIND_RECORD;
          case ($urandom_range(0, 9))
            0: req.event_count = swec_pkg::COUNT_MAX;
            1, 2: req.event_count = $urandom;
            default: req.event_count = $urandom_range(0, 20);
          endcase
          // a zero step merges into the newest bucket
          if ($urandom_range(0, 3) != 0)
            cur_time = cur_time + $urandom_range(1, step_max);
          req.time_stamp = cur_time;
        end else if (pick < 82) begin
          req.kind = swec_pkg::KIND_REFRESH;
          if ($urandom_range(0, 4) == 0)
            cur_time = cur_time + iv;
          else
            cur_time = cur_time + $urandom_range(0, step_max);
          req.time_stamp = cur_time;
        end else if (pick < 87) begin
          req.kind = swec_pkg::KIND_REFRESH;
          req.time_stamp = cur_time - $urandom_range(1, step_max);
        end else if (pick < 91) begin
          req.kind = swec_pkg::KIND_RECORD;
          req.event_count = $urandom_range(0, 20);
          cur_time = cur_time - $urandom_range(1, step_max);
          req.time_stamp = cur_time;
        end else if (pick < 96) begin
          req.kind = swec_pkg::KIND_CLEAR;
        end else begin
          req.kind = KIND_UNUSED;
        end
        pace_sender();
        send_request(req, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (tally_wr_cnt != tally_rd_cnt) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
src/swec_pkg.sv
src/swec_cell.sv
src/sliding_window_event_counter.sv
src/swec_checker.sv
sim/sliding_window_event_counter_test.sv
